// File: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked every clock, quiet during reset.
`define CHK_IMPL(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) else $error(msg);
// Next-cycle implication, quiet during reset.
`define CHK_NEXT(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);
`endif

// File: rtl/rmbb_pkg.sv
// Package: payload types, register map and controller states for the box finder.
package rmbb_pkg;
  typedef struct packed {
    logic signed [15:0] pixel;
    logic               end_of_row;
    logic               end_of_frame;
  } in_item_t;

  typedef struct packed {
    logic        rect_valid;
    logic [9:0]  left_col;
    logic [10:0] right_col;
    logic [9:0]  top_row;
    logic [9:0]  bottom_row;
    logic        overflow;
    logic        last;
  } out_item_t;

  localparam logic [1:0] REG_SIDE_DEV = 2'd0;
  localparam logic [7:0] SIDE_DEV_RESET = 8'd2;

  typedef enum logic [1:0] {
    ST_PIXEL,
    ST_MATCH,
    ST_EMIT,
    ST_EMPTY
  } ctl_state_t;
endpackage

// File: rtl/run_merge_bounding_boxes.sv
// Output: the first box of a frame passes the match state (if the last pixel ends a run),
// the emit state and the output register; boxes then follow at one a cycle while the output
// is not stalled. Throughput: one pixel a cycle, except that a pixel ending a run stalls
// input for the cell match; a pixel ends at most one run. A frame end stalls input while
// stored boxes or the empty-frame item are emitted; input also waits on a held-off result.
// Reset (synchronous, rst high) empties the cell row and sets side_deviation to 2.
module run_merge_bounding_boxes #(
  parameter int MAX_RECTS = 32,
  parameter int MAX_DIM   = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  rmbb_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output rmbb_pkg::out_item_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [1:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import rmbb_pkg::*;

  localparam int CW = $clog2(MAX_DIM) + 1;
  localparam int RW = $clog2(MAX_DIM);
  localparam int NW = $clog2(MAX_RECTS + 1);

  logic [7:0]    side_dev;
  ctl_state_t    state, state_next;
  logic [CW-1:0] col;
  logic [RW-1:0] row;
  logic          in_run;
  logic [CW-2:0] run_start;
  logic          overflow_seen;
  logic [NW-1:0] count;
  logic [NW-1:0] emit_left;
  logic          pend_row;
  logic [CW-1:0] run_end;
  logic          pend_eof;
  logic          pend_second;

  logic [MAX_RECTS:0] claim;
  logic [MAX_RECTS-1:0] cv;
  logic [CW-2:0] cl [MAX_RECTS];
  logic [CW-1:0] cr [MAX_RECTS];
  logic [RW-1:0] ct [MAX_RECTS];
  logic [RW-1:0] cb [MAX_RECTS];

  logic          take;
  logic          fg;
  logic          close_mid;
  logic          close_eor;
  logic          eol;
  logic          shift;
  logic          clear_cells;
  logic          do_test;
  logic          load_new;
  logic          out_load;

  // Configuration port
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      side_dev <= SIDE_DEV_RESET;
    end else if (psel && penable && pwrite && paddr == {REG_SIDE_DEV[0], 1'b0}) begin
      side_dev <= pwdata[7:0];
    end
  end
  assign prdata = (paddr == {REG_SIDE_DEV[0], 1'b0}) ? {24'd0, side_dev} : 32'd0;

  // Pixel classification
  assign take      = in_valid && !in_stall;
  assign fg        = !in_data.pixel[15] && (in_data.pixel != '0) && (col < CW'(MAX_DIM));
  assign eol       = in_data.end_of_row || in_data.end_of_frame;
  assign close_mid = !fg && in_run;
  assign close_eor = eol && (in_run || fg) ;

  // Cell chain
  assign claim[0] = 1'b0;
  assign do_test  = (state == ST_MATCH);
  assign load_new = do_test && !claim[MAX_RECTS] && (count < NW'(MAX_RECTS));
  assign shift    = (state == ST_EMIT) && !(out_valid && out_stall);

  for (genvar i = 0; i < MAX_RECTS; i++) begin : g_cell
    rmbb_cell #(.CW(CW), .RW(RW)) u_cell (
      .clk, .rst, .clear(clear_cells), .shift,
      .valid_in  ((i == MAX_RECTS - 1) ? 1'b0 : cv[(i + 1) % MAX_RECTS]),
      .left_in   (cl[(i + 1) % MAX_RECTS]),
      .right_in  (cr[(i + 1) % MAX_RECTS]),
      .top_in    (ct[(i + 1) % MAX_RECTS]),
      .bottom_in (cb[(i + 1) % MAX_RECTS]),
      .test      (do_test),
      .claim_in  (claim[i]),
      .load      (load_new && count == NW'(i)),
      .run_start, .run_end, .row, .side_dev,
      .claim_out (claim[i+1]),
      .valid     (cv[i]),
      .left_col  (cl[i]),
      .right_col (cr[i]),
      .top_row   (ct[i]),
      .bottom_row(cb[i])
    );
  end
  assign clear_cells = 1'b0;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_PIXEL: begin
        if (take && (close_mid || close_eor)) state_next = ST_MATCH;
        else if (take && in_data.end_of_frame)
          state_next = (count == '0) ? ST_EMPTY : ST_EMIT;
      end
      ST_MATCH: begin
        if (pend_second) state_next = ST_MATCH;
        else if (pend_eof)
          state_next = (count == '0 && !load_new) ? ST_EMPTY : ST_EMIT;
        else state_next = ST_PIXEL;
      end
      ST_EMIT: begin
        if (shift && emit_left == NW'(1)) state_next = ST_PIXEL;
      end
      ST_EMPTY: begin
        if (!(out_valid && out_stall)) state_next = ST_PIXEL;
      end
      default: state_next = ST_PIXEL;
    endcase
  end

  // Outputs of the controller
  always_comb begin
    in_stall = (state != ST_PIXEL) || (out_valid && out_stall);
    out_load = (state == ST_EMIT || state == ST_EMPTY) && !(out_valid && out_stall);
  end

  // Frame counters and pending run
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_PIXEL;
      col <= '0; row <= '0; in_run <= 1'b0; run_start <= '0;
      overflow_seen <= 1'b0; count <= '0; emit_left <= '0;
      pend_eof <= 1'b0; pend_second <= 1'b0; pend_row <= 1'b0; run_end <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      out_valid <= out_load || (out_valid && out_stall);
      if (take) begin
        pend_eof <= in_data.end_of_frame;
        pend_row <= eol && !(in_data.end_of_frame);
        if (close_mid) begin
          run_end <= col;
          pend_second <= close_eor && fg;
        end else begin
          run_end <= col + CW'(1);
          pend_second <= 1'b0;
        end
        if (fg && !in_run) run_start <= col[CW-2:0];
        in_run <= fg && !eol;
        if (eol) col <= '0;
        else if (col < CW'(MAX_DIM)) col <= col + CW'(1);
        if (!close_mid && !close_eor && in_data.end_of_frame) begin
          emit_left <= count;
          row <= '0;
        end else if (!close_mid && !close_eor && eol && row < RW'(MAX_DIM - 1)) begin
          row <= row + RW'(1);
        end
      end
      if (state == ST_MATCH) begin
        if (load_new) count <= count + NW'(1);
        else if (!claim[MAX_RECTS]) overflow_seen <= 1'b1;
        if (pend_second) begin
          pend_second <= 1'b0;
          run_start <= col[CW-2:0];
          run_end <= col + CW'(1);
        end else if (pend_eof) begin
          emit_left <= count + NW'(load_new);
          row <= '0;
        end else if (pend_row && row < RW'(MAX_DIM - 1)) begin
          row <= row + RW'(1);
        end
      end
      if (out_load) begin
        out_data.rect_valid <= (state == ST_EMIT);
        out_data.left_col   <= (state == ST_EMPTY) ? 10'd0 : 10'(cl[0]);
        out_data.right_col  <= (state == ST_EMPTY) ? 11'd0 : 11'(cr[0]);
        out_data.top_row    <= (state == ST_EMPTY) ? 10'd0 : 10'(ct[0]);
        out_data.bottom_row <= (state == ST_EMPTY) ? 10'd0 : 10'(cb[0]);
        out_data.overflow   <= overflow_seen;
        out_data.last       <= (state == ST_EMPTY) || emit_left == NW'(1);
        if (state == ST_EMIT) emit_left <= emit_left - NW'(1);
        if (state == ST_EMPTY || emit_left == NW'(1)) begin
          count <= '0;
          overflow_seen <= 1'b0;
        end
      end
    end
  end
endmodule

// File: rtl/rmbb_cell.sv
// One rectangle cell: holds a box, tests a run against it, shifts towards the output.
module rmbb_cell #(
  parameter int CW = 11,
  parameter int RW = 10
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          clear,
  input  logic          shift,
  input  logic          valid_in,
  input  logic [CW-2:0] left_in,
  input  logic [CW-1:0] right_in,
  input  logic [RW-1:0] top_in,
  input  logic [RW-1:0] bottom_in,
  input  logic          test,
  input  logic          claim_in,
  input  logic          load,
  input  logic [CW-2:0] run_start,
  input  logic [CW-1:0] run_end,
  input  logic [RW-1:0] row,
  input  logic [7:0]    side_dev,
  output logic          claim_out,
  output logic          valid,
  output logic [CW-2:0] left_col,
  output logic [CW-1:0] right_col,
  output logic [RW-1:0] top_row,
  output logic [RW-1:0] bottom_row
);
  logic          hit;
  logic [CW-1:0] dl;
  logic [CW-1:0] dr;
  logic [CW-1:0] rs;
  logic [CW-1:0] lc;

  // Edge distances for the match test
  always_comb begin
    rs = {1'b0, run_start};
    lc = {1'b0, left_col};
    dl = (rs > lc) ? rs - lc : lc - rs;
    dr = (run_end > right_col) ? run_end - right_col : right_col - run_end;
    hit = valid && (row != '0) && (bottom_row + RW'(1) == row) &&
          (dl <= CW'(side_dev)) && (dr <= CW'(side_dev));
  end

  // First matching cell up the chain takes the run
  assign claim_out = claim_in || (test && hit);

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      valid <= 1'b0;
    end else if (shift) begin
      valid <= valid_in;
    end else if (load) begin
      valid <= 1'b1;
    end
    if (shift) begin
      left_col   <= left_in;
      right_col  <= right_in;
      top_row    <= top_in;
      bottom_row <= bottom_in;
    end else if (load) begin
      left_col   <= run_start;
      right_col  <= run_end;
      top_row    <= row;
      bottom_row <= row;
    end else if (test && hit && !claim_in) begin
      bottom_row <= row;
      if (run_start < left_col) left_col <= run_start;
      if (run_end > right_col) right_col <= run_end;
    end
  end
endmodule

// File: rtl/rmbb_checker.sv
// Port checker for the box finder, bound to the top level.
`include "assert_macros.svh"
module rmbb_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input rmbb_pkg::out_item_t out_data
);
  import rmbb_pkg::*;
  `CHK_NEXT(a_in_hold, clk, rst, in_valid && in_stall, in_valid, "stalled pixel withdrawn")
  `CHK_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")
  `CHK_IMPL(a_empty_last, clk, rst, out_valid && !out_data.rect_valid, out_data.last, "empty frame item not last")
  `CHK_IMPL(a_box_order, clk, rst, out_valid && out_data.rect_valid, out_data.top_row <= out_data.bottom_row, "box rows inverted")
  `CHK_IMPL(a_box_cols, clk, rst, out_valid && out_data.rect_valid, {1'b0, out_data.left_col} < out_data.right_col, "box columns inverted")
endmodule

bind run_merge_bounding_boxes rmbb_checker u_rmbb_checker (
  .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .out_data
);
